// ===== hdl/bxh_pkg.sv =====
// shared types and constants for the block xor chain file hash
package bxh_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int FILL_W      = $clog2(BLOCK_BYTES) + 1;
    localparam int IDX_W       = $clog2(BLOCK_BYTES);
    localparam int PREFIX_LVLS = $clog2(BLOCK_BYTES);

    localparam logic [7:0] MIX_SEED = 8'hC9;

    // sixteen bytes, byte 0 in the low bits
    typedef logic [BLOCK_BYTES-1:0][7:0] byte_vec_t;

    // one input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_start;
        logic       clear_hash;
    } in_item_t;

    // hash engine state carried between the state register and the fold logic
    typedef struct packed {
        byte_vec_t         hash_bytes;
        byte_vec_t         pending_block;
        logic [FILL_W-1:0] fill_count;
        logic [7:0]        mix_byte;
        logic [7:0]        block_counter;
    } hash_state_t;

endpackage

// ===== hdl/bxh_if.sv =====
// valid/ready channel interfaces for input bytes and hash results
interface bxh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       chunk_start;
    logic       clear_hash;

    modport source (output valid, output data_byte, output chunk_start,
                    output clear_hash, input ready);
    modport sink   (input valid, input data_byte, input chunk_start,
                    input clear_hash, output ready);
endinterface

interface bxh_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_low;
    logic [63:0] hash_high;

    modport source (output valid, output hash_low, output hash_high, input ready);
    modport sink   (input valid, input hash_low, input hash_high, output ready);
endinterface

// ===== hdl/block_xor_chain_file_hash.sv =====
// top level of the byte-serial xor chain hash with input and result registers
//
//  channel | dir | beat contents                              | accepted when
//  item    | in  | data_byte[7:0], chunk_start, clear_hash    | valid && ready
//  result  | out | hash_low[63:0] (bytes 0..7), hash_high[63:0] (bytes 8..15)
//          |     |                                            | valid && ready
//
// one byte per cycle sustained while results are taken; a beat passes the input
// register, then the fold logic into the result register, before its result is offered.
// rst_n clears the hash, fill count, block counter, mixing byte (0xC9)
// and both valid flags at once; the pending block is not reset. while the
// result is stalled the input register still takes one more beat, then item
// ready drops until the result is taken.
module block_xor_chain_file_hash
(
    input  logic       clk,
    input  logic       rst_n,
    bxh_in_if.sink     item,
    bxh_out_if.source  result
);

    logic                         stage_valid;
    bxh_pkg::in_item_t            stage_item;
    logic                         advance;
    bxh_pkg::hash_state_t         state_cur;
    bxh_pkg::hash_state_t         state_next;
    bxh_pkg::byte_vec_t           hash_reg;
    bxh_pkg::byte_vec_t           pending_reg;
    logic [bxh_pkg::FILL_W-1:0]   fill_reg;
    logic [7:0]                   mix_reg;
    logic [7:0]                   counter_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    bxh_pkg::byte_vec_t           out_hash_reg;

    // held beat moves into the result register when it is free or draining
    assign advance = stage_valid && (!out_valid_reg || result.ready);

    bxh_in_stage u_in_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    // current engine state gathered for the fold logic
    always_comb
    begin
        state_cur.hash_bytes    = hash_reg;
        state_cur.pending_block = pending_reg;
        state_cur.fill_count    = fill_reg;
        state_cur.mix_byte      = mix_reg;
        state_cur.block_counter = counter_reg;
    end

    bxh_fold u_fold
    (
        .cur  (state_cur),
        .beat (stage_item),
        .nxt  (state_next)
    );

    // hash engine state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg    <= '0;
            fill_reg    <= '0;
            mix_reg     <= bxh_pkg::MIX_SEED;
            counter_reg <= 8'd0;
        end
        else if (advance)
        begin
            hash_reg    <= state_next.hash_bytes;
            fill_reg    <= state_next.fill_count;
            mix_reg     <= state_next.mix_byte;
            counter_reg <= state_next.block_counter;
        end
    end

    // pending block has no reset value
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pending_reg <= state_next.pending_block;
        end
    end

    // result register valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg && !result.ready;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_hash_reg <= state_next.hash_bytes;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.hash_low  = out_hash_reg[7:0];
    assign result.hash_high = out_hash_reg[15:8];

endmodule

// ===== hdl/bxh_in_stage.sv =====
// input register stage that captures one beat and holds it until the core takes it
module bxh_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    bxh_in_if.sink            item,
    input  logic              advance,
    output logic              stage_valid,
    output bxh_pkg::in_item_t stage_item
);

    logic              valid_reg;
    logic              valid_next;
    bxh_pkg::in_item_t item_reg;

    // free slot, or the held beat leaves this cycle
    assign item.ready = !valid_reg || advance;

    // occupancy of the stage
    always_comb
    begin
        valid_next = valid_reg;
        if (item.valid && item.ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture, no reset
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_reg.data_byte   <= item.data_byte;
            item_reg.chunk_start <= item.chunk_start;
            item_reg.clear_hash  <= item.clear_hash;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

// ===== hdl/bxh_fold.sv =====
// next-state logic: flag handling, block fold with prefix xor chain, byte store
module bxh_fold
(
    input  bxh_pkg::hash_state_t cur,
    input  bxh_pkg::in_item_t    beat,
    output bxh_pkg::hash_state_t nxt
);

    localparam int NB = bxh_pkg::BLOCK_BYTES;
    localparam int NL = bxh_pkg::PREFIX_LVLS;

    bxh_pkg::byte_vec_t                 hash_pre;
    logic [bxh_pkg::FILL_W-1:0]         fill_pre;
    logic [7:0]                         mix_pre;
    logic [7:0]                         cnt_pre;
    logic                               do_fold;
    bxh_pkg::byte_vec_t [NL:0]          lvl;
    bxh_pkg::byte_vec_t                 hash_fold;
    logic [7:0]                         rot_src;
    logic [bxh_pkg::FILL_W-1:0]         fill_base;

    // clear and chunk restart come before anything else
    always_comb
    begin
        hash_pre = beat.clear_hash ? '0 : cur.hash_bytes;
        fill_pre = beat.chunk_start ? '0 : cur.fill_count;
        mix_pre  = beat.chunk_start ? bxh_pkg::MIX_SEED : cur.mix_byte;
        cnt_pre  = beat.chunk_start ? 8'd0 : cur.block_counter;
        do_fold  = (fill_pre >= bxh_pkg::FILL_W'(NB));
    end

    // bytewise add, mixing byte into byte 0, then a log-depth prefix xor
    always_comb
    begin
        for (int i = 0; i < NB; i++)
        begin
            lvl[0][i] = hash_pre[i] + cur.pending_block[i];
        end
        lvl[0][0] = lvl[0][0] ^ mix_pre;
        for (int l = 0; l < NL; l++)
        begin
            for (int i = 0; i < NB; i++)
            begin
                if (i >= (1 << l))
                begin
                    lvl[l+1][i] = lvl[l][i] ^ lvl[l][i - (1 << l)];
                end
                else
                begin
                    lvl[l+1][i] = lvl[l][i];
                end
            end
        end
        hash_fold = lvl[NL];
        rot_src   = cnt_pre + hash_fold[NB-1];
    end

    // pick folded or plain state, then store the incoming byte
    always_comb
    begin
        nxt.pending_block = cur.pending_block;
        if (do_fold)
        begin
            nxt.hash_bytes    = hash_fold;
            nxt.mix_byte      = {rot_src[6:0], rot_src[7]};
            nxt.block_counter = cnt_pre + 8'd1;
            fill_base         = '0;
        end
        else
        begin
            nxt.hash_bytes    = hash_pre;
            nxt.mix_byte      = mix_pre;
            nxt.block_counter = cnt_pre;
            fill_base         = fill_pre;
        end
        nxt.pending_block[fill_base[bxh_pkg::IDX_W-1:0]] = beat.data_byte;
        nxt.fill_count = fill_base + bxh_pkg::FILL_W'(1);
    end

endmodule

// ===== hdl/bxh_checker.sv =====
// port-level checks for the xor chain hash, bound to the top level
module bxh_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_chunk_start,
    input logic        in_clear_hash,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] out_hash_low,
    input logic [63:0] out_hash_high
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    // a stalled result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_hash_low) && $stable(out_hash_high))
        else $error("result payload changed while stalled");

    // an accepted beat reaches the result through the input register when nothing stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready |=> out_valid)
        else $error("accepted beat produced no result");

    // clear plus chunk start leaves an all-zero hash
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_clear_hash && in_chunk_start) ##1 out_ready
        |=> out_valid && out_hash_low == 64'd0 && out_hash_high == 64'd0)
        else $error("hash not zero after clear at chunk start");

    // input back-pressure only comes from a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

endmodule

bind block_xor_chain_file_hash bxh_checker u_bxh_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (item.valid),
    .in_ready       (item.ready),
    .in_chunk_start (item.chunk_start),
    .in_clear_hash  (item.clear_hash),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_hash_low   (result.hash_low),
    .out_hash_high  (result.hash_high)
);
